FILE: rtl/core/mpm_pkg.sv
// Package for the multiprecision multiplier core: sizes, index widths, op codes
// and payload types. No dependencies; every other file imports it.
package mpm_pkg;

   localparam int OPERAND_WORDS   = 96;
   localparam int PRODUCT_WORDS   = 2 * OPERAND_WORDS;
   localparam int WORD_BITS       = 32;
   localparam int INDEX_BITS      = 8;
   // multiplier digit consumed per cycle; must divide WORD_BITS
   localparam int DIGIT_BITS      = 8;
   localparam int DIGITS_PER_WORD = WORD_BITS / DIGIT_BITS;

   localparam int OP_ADDR_BITS    = (OPERAND_WORDS > 1) ? $clog2(OPERAND_WORDS) : 1;
   localparam int PROD_ADDR_BITS  = $clog2(PRODUCT_WORDS);
   localparam int DIGIT_CNT_BITS  = (DIGITS_PER_WORD > 1) ? $clog2(DIGITS_PER_WORD) : 1;

   // running high part of word product + addend, and one digit step sum
   localparam int ACC_BITS        = WORD_BITS + 1;
   localparam int PART_BITS       = WORD_BITS + DIGIT_BITS;
   localparam int SUM_BITS        = WORD_BITS + DIGIT_BITS + 1;

   typedef enum logic [1:0] {
      OP_LOAD_A   = 2'd0,
      OP_LOAD_B   = 2'd1,
      OP_MULTIPLY = 2'd2,
      OP_READ     = 2'd3
   } op_type;

   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [INDEX_BITS-1:0] index_type;

endpackage

FILE: rtl/core/mpm_if.sv
// Valid/ready channel interfaces for the multiprecision multiplier core.
// Depends on mpm_pkg for the op code and payload types.
interface mpm_req_if;
   import mpm_pkg::*;

   logic      valid;
   logic      ready;
   op_type    op;
   index_type word_index;
   word_type  word_value;

   modport source (output valid, output op, output word_index, output word_value,
                   input ready);
   modport sink   (input valid, input op, input word_index, input word_value,
                   output ready);
endinterface

interface mpm_rsp_if;
   import mpm_pkg::*;

   logic      valid;
   logic      ready;
   word_type  product_word;
   index_type product_index;

   modport source (output valid, output product_word, output product_index,
                   input ready);
   modport sink   (input valid, input product_word, input product_index,
                   output ready);
endinterface

FILE: rtl/core/multiprecision_multiplier_core.sv
// Multiprecision multiplier core: operand/product stores, digit-serial
// schoolbook multiply sequencer, read response path. Depends on mpm_pkg, mpm_if.
//
//   channel  | dir | handshake    | payload
//   ---------+-----+--------------+---------------------------------------
//   req_ch   | in  | valid/ready  | op, word_index, word_value
//   rsp_ch   | out | valid/ready  | product_word, product_index
//
// Loads and reads: one transaction per cycle while intake is open; a read's response
// passes the registered RAM read, then the output register, and holds while rsp_ch stalls.
// Multiply: intake stops until the sequencer returns to idle: per word pair fetch, load,
// DIGITS_PER_WORD 32x8 multiply-add steps and a write, plus one carry write per row.
// Reset: a clearing pass over all PRODUCT_WORDS addresses zeroes all three stores; intake waits.
// A stalled response holds one result plus one read in flight; intake waits.
module multiprecision_multiplier_core (
   input  logic              clock,
   input  logic              reset,
   mpm_req_if.sink           req_ch,
   mpm_rsp_if.source         rsp_ch
);
   import mpm_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_FETCH   = 3'd1;   // issue reads of a[i], b[j], p[i+j]
   localparam logic [2:0] S_LOAD    = 3'd2;   // load shift registers
   localparam logic [2:0] S_MUL     = 3'd3;   // one multiplier digit per cycle
   localparam logic [2:0] S_WRITE   = 3'd4;   // p[i+j] <= low word, keep carry
   localparam logic [2:0] S_ROW_END = 3'd5;   // p[i+N] <= carry

   // ---------------------------------------------------------------- control
   logic [2:0]                state_ff, state_in;
   logic [OP_ADDR_BITS-1:0]   row_ff, row_in;
   logic [OP_ADDR_BITS-1:0]   col_ff, col_in;
   logic [DIGIT_CNT_BITS-1:0] dig_ff, dig_in;

   // clearing pass after reset
   logic                      clr_busy_ff, clr_busy_in;
   logic [PROD_ADDR_BITS-1:0] clr_addr_ff, clr_addr_in;

   // ------------------------------------------------------------- datapath
   word_type                  carry_ff, carry_in;
   word_type                  mcand_ff, mcand_in;   // a[i]
   word_type                  mplier_ff, mplier_in; // b[j], shifts right a digit a cycle
   word_type                  low_ff, low_in;       // product digits shift in at the top
   logic [ACC_BITS-1:0]       acc_ff, acc_in;
   logic [PART_BITS-1:0]      part;
   logic [SUM_BITS-1:0]       sum;

   // ------------------------------------------------------------- storage
   word_type                  a_mem [OPERAND_WORDS];
   word_type                  b_mem [OPERAND_WORDS];
   word_type                  p_mem [PRODUCT_WORDS];

   word_type                  a_rdata_ff, b_rdata_ff, p_rdata_ff;
   logic                      p_rvld_ff;
   word_type                  a_word, b_word, p_word;

   // ---------------------------------------------------------- response path
   logic                      rd_pend_ff, rd_pend_in;
   index_type                 rd_idx_ff;
   logic                      rsp_valid_ff, rsp_valid_in;
   word_type                  rsp_word_ff;
   index_type                 rsp_index_ff;

   // ------------------------------------------------------------- handshake
   logic                      req_fire, rsp_move;
   logic                      load_a, load_b, mult_start, read_fire;
   logic                      op_in_range, prod_in_range;

   logic [OP_ADDR_BITS-1:0]   op_addr, ab_waddr;
   logic                      clr_ab, a_we, b_we;
   word_type                  ab_wdata;
   logic [PROD_ADDR_BITS-1:0] pair_addr, top_addr, req_paddr;
   logic [PROD_ADDR_BITS-1:0] p_raddr, p_waddr;
   logic                      p_ren, p_rd_ok, p_we, ab_ren;
   word_type                  p_wdata;

   // pending read moves to the output register when that register frees up
   assign rsp_move  = rd_pend_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !clr_busy_ff && (state_ff == S_IDLE) && (!rd_pend_ff || rsp_move);
   assign req_fire  = req_ch.valid && req_ch.ready;

   assign op_in_range   = int'(req_ch.word_index) < OPERAND_WORDS;
   assign prod_in_range = int'(req_ch.word_index) < PRODUCT_WORDS;

   assign load_a     = req_fire && (req_ch.op == OP_LOAD_A) && op_in_range;
   assign load_b     = req_fire && (req_ch.op == OP_LOAD_B) && op_in_range;
   assign mult_start = req_fire && (req_ch.op == OP_MULTIPLY);
   assign read_fire  = req_fire && (req_ch.op == OP_READ);

   assign op_addr   = op_in_range ? OP_ADDR_BITS'(req_ch.word_index) : '0;
   assign req_paddr = prod_in_range ? PROD_ADDR_BITS'(req_ch.word_index) : '0;
   assign pair_addr = PROD_ADDR_BITS'(row_ff) + PROD_ADDR_BITS'(col_ff);
   assign top_addr  = PROD_ADDR_BITS'(row_ff) + PROD_ADDR_BITS'(OPERAND_WORDS);

   // operand RAM write muxing; the clearing pass owns the ports while busy
   assign clr_ab   = clr_busy_ff && (int'(clr_addr_ff) < OPERAND_WORDS);
   assign a_we     = load_a || clr_ab;
   assign b_we     = load_b || clr_ab;
   assign ab_waddr = clr_busy_ff ? OP_ADDR_BITS'(clr_addr_ff) : op_addr;
   assign ab_wdata = clr_busy_ff ? '0 : req_ch.word_value;

   // product RAM port muxing
   assign ab_ren  = (state_ff == S_FETCH);
   assign p_ren   = ab_ren || read_fire;
   // row 0 starts from an empty product, so old product words are ignored there
   assign p_rd_ok = ab_ren ? (row_ff != '0) : prod_in_range;
   assign p_raddr = ab_ren ? pair_addr : req_paddr;
   assign p_we    = clr_busy_ff || (state_ff == S_WRITE) || (state_ff == S_ROW_END);
   assign p_waddr = clr_busy_ff ? clr_addr_ff :
                    (state_ff == S_WRITE) ? pair_addr : top_addr;
   assign p_wdata = clr_busy_ff ? '0 :
                    (state_ff == S_WRITE) ? low_ff : carry_ff;

   // out-of-range reads and row 0 of a multiply see zero
   assign a_word = a_rdata_ff;
   assign b_word = b_rdata_ff;
   assign p_word = p_rvld_ff ? p_rdata_ff : '0;

   // ------------------------------------------------------------- RAMs
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[ab_waddr] <= ab_wdata;
      end
      if (b_we) begin
         b_mem[ab_waddr] <= ab_wdata;
      end
      if (ab_ren) begin
         a_rdata_ff <= a_mem[row_ff];
         b_rdata_ff <= b_mem[col_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (p_we) begin
         p_mem[p_waddr] <= p_wdata;
      end
      if (p_ren) begin
         p_rdata_ff <= p_mem[p_raddr];
         p_rvld_ff  <= p_rd_ok;
      end
   end

   // ---------------------------------------------------------- clearing pass
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         if (clr_addr_ff == PROD_ADDR_BITS'(PRODUCT_WORDS - 1)) begin
            clr_busy_in = 1'b0;
         end else begin
            clr_addr_in = clr_addr_ff + 1'b1;
         end
      end
   end

   // ---------------------------------------------------- digit step datapath
   // sum = running high part + a[i] * current digit of b[j]
   assign part = mcand_ff * mplier_ff[DIGIT_BITS-1:0];
   assign sum  = SUM_BITS'(acc_ff) + SUM_BITS'(part);

   // --------------------------------------------------------- sequencer
   always_comb begin
      state_in  = state_ff;
      row_in    = row_ff;
      col_in    = col_ff;
      dig_in    = dig_ff;
      carry_in  = carry_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      low_in    = low_ff;
      acc_in    = acc_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (mult_start) begin
               state_in = S_FETCH;
               row_in   = '0;
               col_in   = '0;
               carry_in = '0;
            end
         end
         S_FETCH: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            // t = a*b + p[i+j] + carry fits in two words
            mcand_in  = a_word;
            mplier_in = b_word;
            acc_in    = ACC_BITS'(p_word) + ACC_BITS'(carry_ff);
            dig_in    = '0;
            state_in  = S_MUL;
         end
         S_MUL: begin
            low_in    = {sum[DIGIT_BITS-1:0], low_ff[WORD_BITS-1:DIGIT_BITS]};
            acc_in    = ACC_BITS'(sum >> DIGIT_BITS);
            mplier_in = mplier_ff >> DIGIT_BITS;
            dig_in    = dig_ff + 1'b1;
            if (dig_ff == DIGIT_CNT_BITS'(DIGITS_PER_WORD - 1)) begin
               state_in = S_WRITE;
            end
         end
         S_WRITE: begin
            carry_in = acc_ff[WORD_BITS-1:0];
            if (col_ff == OP_ADDR_BITS'(OPERAND_WORDS - 1)) begin
               col_in   = '0;
               state_in = S_ROW_END;
            end else begin
               col_in   = col_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         S_ROW_END: begin
            carry_in = '0;
            if (row_ff == OP_ADDR_BITS'(OPERAND_WORDS - 1)) begin
               row_in   = '0;
               state_in = S_IDLE;
            end else begin
               row_in   = row_ff + 1'b1;
               state_in = S_FETCH;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         row_ff      <= '0;
         col_ff      <= '0;
         dig_ff      <= '0;
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else begin
         state_ff    <= state_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         dig_ff      <= dig_in;
         clr_busy_ff <= clr_busy_in;
         clr_addr_ff <= clr_addr_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff  <= carry_in;
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      low_ff    <= low_in;
      acc_ff    <= acc_in;
   end

   // --------------------------------------------------------- response path
   always_comb begin
      rd_pend_in = rd_pend_ff;
      if (read_fire) begin
         rd_pend_in = 1'b1;
      end else if (rsp_move) begin
         rd_pend_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (rsp_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (read_fire) begin
         rd_idx_ff <= req_ch.word_index;
      end
      if (rsp_move) begin
         rsp_word_ff  <= p_word;
         rsp_index_ff <= rd_idx_ff;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.product_word  = rsp_word_ff;
   assign rsp_ch.product_index = rsp_index_ff;

endmodule

FILE: rtl/core/mpm_core_checker.sv
// Port-level checks for multiprecision_multiplier_core, attached by bind.
// Depends on mpm_pkg and the core's channel interfaces.
module mpm_core_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input mpm_pkg::op_type    req_op,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input mpm_pkg::word_type  rsp_product_word,
   input mpm_pkg::index_type rsp_product_index
);
   import mpm_pkg::*;

   // stalled response holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         rsp_valid && $stable(rsp_product_word) && $stable(rsp_product_index))
      else $error("response changed while stalled");

   // reads past the product return zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (int'(rsp_product_index) >= PRODUCT_WORDS) |->
         (rsp_product_word == '0))
      else $error("out of range read returned nonzero data");

   // multiply transaction holds intake off in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_MULTIPLY) |=> !req_ready)
      else $error("intake open right after multiply");

   // no response straight out of reset
   assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind multiprecision_multiplier_core mpm_core_checker u_mpm_core_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_op            (req_ch.op),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_product_word  (rsp_ch.product_word),
   .rsp_product_index (rsp_ch.product_index)
);

FILE: tb/multiprecision_multiplier_core_test.sv
// Self-checking test of multiprecision_multiplier_core: operand loads, multiplies and product
// reads checked against a shadow word-level product. Needs mpm_pkg, mpm_if and the core RTL.
`timescale 1ns / 100ps

module multiprecision_multiplier_core_test;
   import mpm_pkg::*;

   // A multiply stalls intake for its whole fetch/load/multiply/write sequence, so the
   // no-progress limit has to sit well above one multiply.
   localparam int IDLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES = 20;
   localparam int RANDOM_PHASES = 8;
   // phase that fills both operands with all ones: worst-case carry chain
   localparam int ALL_ONES_PHASE = 3;

   typedef struct {
      op_type    op;
      index_type index;
      word_type  value;
   } request_item_type;

   typedef struct {
      word_type  word;
      index_type index;
   } product_read_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mpm_req_if req_ch ();
   mpm_rsp_if rsp_ch ();

   multiprecision_multiplier_core i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always #1 clock = ~clock;

   // stimulus not yet sent, and product reads whose answer is still due
   request_item_type request_queue [$];
   product_read_type pending_reads [$];

   // shadow copies of the core's stores
   word_type shadow_a       [OPERAND_WORDS];
   word_type shadow_b       [OPERAND_WORDS];
   word_type shadow_product [PRODUCT_WORDS];

   int unsigned error_count    = 0;
   int unsigned accepted_count = 0;
   int unsigned reads_checked  = 0;
   int unsigned multiply_count = 0;
   int unsigned ignored_loads  = 0;
   int unsigned idle_cycles    = 0;
   logic        req_taken      = 1'b0;

   // driver pacing and receiver stall pattern
   int unsigned burst_left = 0;
   int unsigned gap_left   = 0;
   int unsigned ready_mode = 0;
   int unsigned mode_left  = 0;
   int unsigned ready_tick = 0;

   function automatic void queue_request(op_type op, int unsigned index, word_type value);
      request_item_type item;
      item.op    = op;
      item.index = index_type'(index);
      item.value = value;
      request_queue.push_back(item);
   endfunction

   // operand words biased toward the corners of the carry logic
   function automatic word_type pick_word();
      word_type w;
      case ($urandom_range(0, 7))
         0: w = '1;
         1: w = '0;
         2: w = word_type'(1) << $urandom_range(0, WORD_BITS - 1);
         3: w = ~(word_type'(1) << $urandom_range(0, WORD_BITS - 1));
         default: w = $urandom;
      endcase
      return w;
   endfunction

   // Update the shadow state for one accepted transaction; a read queues the
   // word the core must return. Multiply is plain word-by-word schoolbook;
   // the core's internal digit size does not matter for the exact product.
   task automatic apply_request(input op_type op, input index_type index,
                                input word_type value);
      product_read_type expected_read;
      logic [63:0]      column;
      word_type         carry;
      case (op)
         OP_LOAD_A: begin
            if (index < OPERAND_WORDS) shadow_a[index] = value;
            else ignored_loads++;
         end
         OP_LOAD_B: begin
            if (index < OPERAND_WORDS) shadow_b[index] = value;
            else ignored_loads++;
         end
         OP_MULTIPLY: begin
            foreach (shadow_product[k]) shadow_product[k] = '0;
            for (int i = 0; i < OPERAND_WORDS; i++) begin
               carry = '0;
               for (int j = 0; j < OPERAND_WORDS; j++) begin
                  column = 64'(shadow_a[i]) * 64'(shadow_b[j])
                         + 64'(shadow_product[i + j]) + 64'(carry);
                  shadow_product[i + j] = column[31:0];
                  carry = column[63:32];
               end
               shadow_product[i + OPERAND_WORDS] = carry;
            end
            multiply_count++;
         end
         OP_READ: begin
            expected_read.index = index;
            // out-of-range reads come back as zero
            expected_read.word  = (index < PRODUCT_WORDS) ? shadow_product[index] : '0;
            pending_reads.push_back(expected_read);
         end
      endcase
   endtask

   // Driver: inputs change on the falling edge. A transaction accepted at the
   // last rising edge is retired here and the next one (or a gap) follows.
   // valid gets exactly one nonblocking write per edge.
   always @(negedge clock) begin : drive_inputs
      request_item_type next_item;
      logic             drive_valid;
      logic             drive_ready;
      drive_valid = req_ch.valid;
      if (reset) begin
         drive_valid = 1'b0;
      end else begin
         if (req_taken) drive_valid = 1'b0;
         if (!drive_valid) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (request_queue.size() > 0) begin
               next_item = request_queue.pop_front();
               req_ch.op         <= next_item.op;
               req_ch.word_index <= next_item.index;
               req_ch.word_value <= next_item.value;
               drive_valid = 1'b1;
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  // new burst; some bursts are long with no gap at all
                  burst_left = $urandom_range(0, 40);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
      end
      req_ch.valid <= drive_valid;

      // Receiver: stall style changes every so often - always ready, coin
      // flip, fixed 3-of-8 stall pattern, or mostly stalled.
      if (mode_left == 0) begin
         ready_mode = $urandom_range(0, 3);
         mode_left  = $urandom_range(16, 200);
      end else begin
         mode_left--;
      end
      ready_tick++;
      case (ready_mode)
         0: drive_ready = 1'b1;
         1: drive_ready = 1'($urandom_range(0, 1));
         2: drive_ready = (ready_tick % 8) < 5;
         default: drive_ready = ($urandom_range(0, 3) == 0);
      endcase
      rsp_ch.ready <= reset ? 1'b0 : drive_ready;
   end

   // Monitor: both channels sampled on the rising edge. The request side is
   // handled first so a read's expectation is always queued before any
   // response could answer it.
   always @(posedge clock) begin : check_outputs
      product_read_type want;
      logic             progress;
      req_taken = 1'b0;
      progress  = 1'b0;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            req_taken = 1'b1;
            progress  = 1'b1;
            accepted_count++;
            apply_request(req_ch.op, req_ch.word_index, req_ch.word_value);
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            progress = 1'b1;
            if (pending_reads.size() == 0) begin
               $error("unexpected response: product_index %0d product_word 0x%08h",
                      rsp_ch.product_index, rsp_ch.product_word);
               error_count++;
            end else begin
               want = pending_reads.pop_front();
               reads_checked++;
               if (rsp_ch.product_index !== want.index) begin
                  $error("product_index: expected %0d, actual %0d",
                         want.index, rsp_ch.product_index);
                  error_count++;
               end
               if (rsp_ch.product_word !== want.word) begin
                  $error("product_word: expected 0x%08h, actual 0x%08h",
                         want.word, rsp_ch.product_word);
                  error_count++;
               end
            end
         end
      end
      idle_cycles <= progress ? 0 : idle_cycles + 1;
   end

   // watchdog: nothing accepted on either channel for too long
   always @(posedge clock) begin
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transaction for %0d cycles", idle_cycles);
         $display("tb: failure");
         $finish;
      end
   end

   initial begin
      int unsigned load_count;
      int unsigned read_count;
      int unsigned index;

      req_ch.valid      = 1'b0;
      req_ch.op         = OP_LOAD_A;
      req_ch.word_index = '0;
      req_ch.word_value = '0;
      rsp_ch.ready      = 1'b0;
      foreach (shadow_a[k]) shadow_a[k] = '0;
      foreach (shadow_b[k]) shadow_b[k] = '0;
      foreach (shadow_product[k]) shadow_product[k] = '0;

      // --- directed part ---
      // product store is zero after reset; out-of-range read is zero too
      queue_request(OP_READ, 0, $urandom);
      queue_request(OP_READ, 255, $urandom);
      // extreme words at both ends of each operand, plus ignored loads
      queue_request(OP_LOAD_A, 0, '1);
      queue_request(OP_LOAD_A, OPERAND_WORDS - 1, '1);
      queue_request(OP_LOAD_A, OPERAND_WORDS, 32'h1234_5678);
      queue_request(OP_LOAD_B, 0, '1);
      queue_request(OP_LOAD_B, OPERAND_WORDS - 1, 32'h8000_0001);
      queue_request(OP_LOAD_B, 255, '1);
      // read before the multiply still sees the old product
      queue_request(OP_READ, 0, '0);
      queue_request(OP_MULTIPLY, 255, '1);
      queue_request(OP_READ, 0, '0);
      queue_request(OP_READ, 1, '0);
      queue_request(OP_READ, OPERAND_WORDS - 1, '0);
      queue_request(OP_READ, OPERAND_WORDS, '0);
      queue_request(OP_READ, PRODUCT_WORDS - 2, '0);
      queue_request(OP_READ, PRODUCT_WORDS - 1, '1);
      queue_request(OP_READ, PRODUCT_WORDS, '1);
      queue_request(OP_READ, 128, '0);
      // zero operand gives a zero product
      queue_request(OP_LOAD_A, 0, '0);
      queue_request(OP_LOAD_A, OPERAND_WORDS - 1, '0);
      queue_request(OP_MULTIPLY, 0, '0);
      queue_request(OP_READ, 0, '0);
      queue_request(OP_READ, PRODUCT_WORDS - 1, '0);
      queue_request(OP_READ, 100, '0);

      // --- random part: load a set of words, multiply, read the product ---
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase == ALL_ONES_PHASE) begin
            for (int w = 0; w < OPERAND_WORDS; w++) begin
               queue_request(OP_LOAD_A, w, '1);
               queue_request(OP_LOAD_B, w, '1);
            end
         end else begin
            load_count = $urandom_range(30, 70);
            for (int n = 0; n < load_count; n++) begin
               // a few stale reads mixed into the loads
               if ($urandom_range(0, 9) == 0) begin
                  queue_request(OP_READ, $urandom_range(0, 255), $urandom);
               end else begin
                  index = ($urandom_range(0, 9) == 0) ? $urandom_range(OPERAND_WORDS, 255)
                                                      : $urandom_range(0, OPERAND_WORDS - 1);
                  queue_request($urandom_range(0, 1) ? OP_LOAD_B : OP_LOAD_A, index,
                                pick_word());
               end
            end
         end
         queue_request(OP_MULTIPLY, $urandom_range(0, 255), $urandom);
         read_count = $urandom_range(40, 70);
         for (int n = 0; n < read_count; n++) begin
            index = ($urandom_range(0, 9) == 0) ? $urandom_range(PRODUCT_WORDS, 255)
                                                : $urandom_range(0, PRODUCT_WORDS - 1);
            queue_request(OP_READ, index, $urandom);
         end
      end

      // single reset at the start, released on a falling edge
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (request_queue.size() != 0 || req_ch.valid || pending_reads.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("run: %0d transactions accepted, %0d multiplies, %0d product reads checked",
               accepted_count, multiply_count, reads_checked);
      $display("run: %0d out-of-range loads ignored, %0d errors", ignored_loads, error_count);
      if (error_count == 0 && pending_reads.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
rtl/core/mpm_pkg.sv
rtl/core/mpm_if.sv
rtl/core/multiprecision_multiplier_core.sv
rtl/core/mpm_core_checker.sv
tb/multiprecision_multiplier_core_test.sv
